[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ERM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ERM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/erm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package erm_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int SERIES_TERMS      = 8;

  // Q30 fixed point: 1.0 = 2^30
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sincos_t;

  // Signed Q30 product, rounded half away from zero.
  function automatic logic signed [31:0] qmul_s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [31:0] m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    pr  = 64'(ma) * 64'(mb) + (64'd1 << 29);
    m   = pr[61:30];
    return neg ? $signed(32'(-m)) : $signed(m);
  endfunction

endpackage
`default_nettype wire

[rtl/euler_rotation_matrix_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Euler angles to rotation matrix. Each transaction takes three binary angles
// (full turn = 2^ANGLE_BITS) and returns the nine non-constant elements of the
// rotation matrix as signed Q1.FRACTION_BITS, saturated to +/-1.0. The block
// is fully pipelined: a new transaction may start every cycle, busy stays low,
// and out_valid pulses for one cycle per transaction. The path runs through
// the angle, square, eight Horner steps of three stages each, sine product and
// quadrant unfold stages, then the product, sum and rounding stages. There is no
// output hold: the receiver must take each result in the cycle it appears.
module euler_rotation_matrix_unit #(
  parameter int ANGLE_BITS    = erm_pkg::ANGLE_BITS_DEF,
  parameter int FRACTION_BITS = erm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ANGLE_BITS-1:0]          in_angle_x,
  input  wire logic [ANGLE_BITS-1:0]          in_angle_y,
  input  wire logic [ANGLE_BITS-1:0]          in_angle_z,
  output logic                                out_valid,
  output logic signed [FRACTION_BITS+1:0]     out_m0,
  output logic signed [FRACTION_BITS+1:0]     out_m1,
  output logic signed [FRACTION_BITS+1:0]     out_m2,
  output logic signed [FRACTION_BITS+1:0]     out_m4,
  output logic signed [FRACTION_BITS+1:0]     out_m5,
  output logic signed [FRACTION_BITS+1:0]     out_m6,
  output logic signed [FRACTION_BITS+1:0]     out_m8,
  output logic signed [FRACTION_BITS+1:0]     out_m9,
  output logic signed [FRACTION_BITS+1:0]     out_m10
);
  import erm_pkg::*;
  `include "assert_macros.svh"

  localparam int OW  = FRACTION_BITS + 2;
  localparam int SH  = 30 - FRACTION_BITS;
  localparam int LIM = 1 << FRACTION_BITS;

  function automatic logic signed [OW-1:0] to_out(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [34:0] rnd;
    logic [34:0] m;
    logic [OW-1:0] r;
    mag = v[32] ? 33'(-v) : 33'(v);
    rnd = ((35'(mag) << 1) + (35'd1 << SH)) >> (SH + 1);
    m   = (rnd > 35'(LIM)) ? 35'(LIM) : rnd;
    r   = v[32] ? OW'(-m) : OW'(m);
    return $signed(r);
  endfunction

  logic    vx, vy, vz;
  sincos_t scx, scy, scz;

  // angle_x feeds the z-term, angle_z the x-term
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk(clk), .rst_n(rst_n), .vld_i(start), .angle_i(in_angle_x),
    .vld_o(vz), .sc_o(scz)
  );
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk(clk), .rst_n(rst_n), .vld_i(start), .angle_i(in_angle_y),
    .vld_o(vy), .sc_o(scy)
  );
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk(clk), .rst_n(rst_n), .vld_i(start), .angle_i(in_angle_z),
    .vld_o(vx), .sc_o(scx)
  );

  assign busy = 1'b0;

  // M1: shared sy products
  logic               v1_r;
  sincos_t            x1_r, y1_r, z1_r;
  logic signed [31:0] p_r, q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= vx & vy & vz;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= scx;
    y1_r <= scy;
    z1_r <= scz;
    p_r  <= qmul_s(scy.s, scz.s);
    q_r  <= qmul_s(scy.s, scz.c);
  end

  // M2: element products
  logic               v2_r;
  logic signed [31:0] cxcy_r, cysx_r, nsy_r, cxp_r, czsx_r, cxcz_r, sxp_r;
  logic signed [31:0] cysz_r, cxq_r, sxsz_r, sxq_r, cxsz_r, cycz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cxcy_r <= qmul_s(x1_r.c, y1_r.c);
    cysx_r <= qmul_s(y1_r.c, x1_r.s);
    nsy_r  <= -y1_r.s;
    cxp_r  <= qmul_s(x1_r.c, p_r);
    czsx_r <= qmul_s(z1_r.c, x1_r.s);
    cxcz_r <= qmul_s(x1_r.c, z1_r.c);
    sxp_r  <= qmul_s(x1_r.s, p_r);
    cysz_r <= qmul_s(y1_r.c, z1_r.s);
    cxq_r  <= qmul_s(x1_r.c, q_r);
    sxsz_r <= qmul_s(x1_r.s, z1_r.s);
    sxq_r  <= qmul_s(x1_r.s, q_r);
    cxsz_r <= qmul_s(x1_r.c, z1_r.s);
    cycz_r <= qmul_s(y1_r.c, z1_r.c);
  end

  // M3: sums, exact at 33 bits
  logic               v3_r;
  logic signed [32:0] e0_r, e1_r, e2_r, e4_r, e5_r, e6_r, e8_r, e9_r, e10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    e0_r  <= 33'(cxcy_r);
    e1_r  <= 33'(cysx_r);
    e2_r  <= 33'(nsy_r);
    e4_r  <= 33'(cxp_r) - 33'(czsx_r);
    e5_r  <= 33'(cxcz_r) + 33'(sxp_r);
    e6_r  <= 33'(cysz_r);
    e8_r  <= 33'(cxq_r) + 33'(sxsz_r);
    e9_r  <= 33'(sxq_r) - 33'(cxsz_r);
    e10_r <= 33'(cycz_r);
  end

  // M4: round and saturate into the output registers
  logic                 vo_r;
  logic signed [OW-1:0] m0_r, m1_r, m2_r, m4_r, m5_r, m6_r, m8_r, m9_r, m10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    m0_r  <= to_out(e0_r);
    m1_r  <= to_out(e1_r);
    m2_r  <= to_out(e2_r);
    m4_r  <= to_out(e4_r);
    m5_r  <= to_out(e5_r);
    m6_r  <= to_out(e6_r);
    m8_r  <= to_out(e8_r);
    m9_r  <= to_out(e9_r);
    m10_r <= to_out(e10_r);
  end

  assign out_valid = vo_r;
  assign out_m0    = m0_r;
  assign out_m1    = m1_r;
  assign out_m2    = m2_r;
  assign out_m4    = m4_r;
  assign out_m5    = m5_r;
  assign out_m6    = m6_r;
  assign out_m8    = m8_r;
  assign out_m9    = m9_r;
  assign out_m10   = m10_r;

  `ERM_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid, "valid survived reset")
  `ERM_ASSERT(a_lanes_aligned, (vx == vy) && (vy == vz), "sine/cosine lanes out of step")
  `ERM_ASSERT(a_m5_range, out_valid |-> (out_m5 <= LIM) && (out_m5 >= -LIM), "m5 out of range")
  `ERM_ASSERT(a_m9_range, out_valid |-> (out_m9 <= LIM) && (out_m9 >= -LIM), "m9 out of range")

endmodule
`default_nettype wire

[rtl/erm_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none
module erm_sincos #(
  parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  vld_i,
  input  wire logic [ANGLE_BITS-1:0] angle_i,
  output logic                       vld_o,
  output erm_pkg::sincos_t           sc_o
);
  import erm_pkg::*;

  localparam int SH = 32 - ANGLE_BITS;

  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [1:0]  quad;
  } ctx_t;

  // Stage A: angle to radians
  logic [29:0] u;
  logic [61:0] xa;
  logic        va_r;
  logic [30:0] xa_r;
  logic [1:0]  qa_r;

  always_comb begin
    u  = 30'(angle_i[ANGLE_BITS-3:0]) << SH;
    xa = 62'(u) * 62'(HALF_PI_Q30) + (62'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    xa_r <= xa[60:30];
    qa_r <= angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
  end

  // Stage B: square
  logic [61:0] sq;
  logic        vb_r;
  ctx_t        cb_r;

  assign sq = 62'(xa_r) * 62'(xa_r) + (62'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    cb_r.x    <= xa_r;
    cb_r.x2   <= sq[61:30];
    cb_r.quad <= qa_r;
  end

  // Horner steps, three stages each; index 0 is sine, 1 is cosine
  logic [30:0] t_b   [0:SERIES_TERMS][0:1];
  ctx_t        ctx_b [0:SERIES_TERMS];
  logic        vld_b [0:SERIES_TERMS];

  assign t_b[0][0] = Q30_ONE;
  assign t_b[0][1] = Q30_ONE;
  assign ctx_b[0]  = cb_r;
  assign vld_b[0]  = vb_r;

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    localparam int N = SERIES_TERMS - i;
    logic va_s_r, vb_s_r, vc_s_r;
    ctx_t ca_r, cbb_r, cc_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_s_r <= 1'b0;
        vb_s_r <= 1'b0;
        vc_s_r <= 1'b0;
      end else begin
        va_s_r <= vld_b[i];
        vb_s_r <= va_s_r;
        vc_s_r <= vb_s_r;
      end
    end

    always_ff @(posedge clk) begin
      ca_r  <= ctx_b[i];
      cbb_r <= ca_r;
      cc_r  <= cbb_r;
    end

    assign vld_b[i+1] = vc_s_r;
    assign ctx_b[i+1] = cc_r;

    for (genvar j = 0; j < 2; j++) begin : g_ser
      localparam int unsigned D      = (j == 0) ? (2*N) * (2*N + 1) : (2*N - 1) * (2*N);
      localparam int unsigned HALF_D = D / 2;
      localparam int          K      = 32 + $clog2(D);
      localparam logic [32:0] M      = 33'((65'd1 << K) / D);

      logic [63:0] pa;
      logic [31:0] prod_r;
      logic [32:0] nn;
      logic [65:0] pb;
      logic [32:0] nn_r;
      logic [31:0] est_r;
      logic [40:0] ed;
      logic [41:0] rem;
      logic [32:0] q;
      logic [30:0] t_nxt;
      logic [30:0] t_r;

      always_comb begin
        pa = 64'(t_b[i][j]) * 64'(ctx_b[i].x2) + (64'd1 << 29);
        nn = 33'(prod_r) + 33'(HALF_D);
        pb = 66'(nn) * 66'(M);
      end

      // Reciprocal estimate is low by at most one; fix with one compare.
      always_comb begin
        ed  = 41'(est_r) * 41'(D);
        rem = 42'(nn_r) - 42'(ed);
        q   = (rem >= 42'(D)) ? 33'(est_r) + 33'd1 : 33'(est_r);
        t_nxt = (q > 33'(Q30_ONE)) ? '0 : 31'(33'(Q30_ONE) - q);
      end

      always_ff @(posedge clk) begin
        prod_r <= pa[61:30];
        nn_r   <= nn;
        est_r  <= 32'(pb >> K);
        t_r    <= t_nxt;
      end

      assign t_b[i+1][j] = t_r;
    end
  end

  // Stage S: final sine product
  ctx_t        ce;
  logic [61:0] ps;
  logic [31:0] sraw;
  logic        vs_r;
  logic [30:0] s_r;
  logic [30:0] c_r;
  logic [1:0]  qs_r;

  always_comb begin
    ce   = ctx_b[SERIES_TERMS];
    ps   = 62'(ce.x) * 62'(t_b[SERIES_TERMS][0]) + (62'd1 << 29);
    sraw = ps[61:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= vld_b[SERIES_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    s_r  <= (sraw > 32'(Q30_ONE)) ? Q30_ONE : 31'(sraw);
    c_r  <= t_b[SERIES_TERMS][1];
    qs_r <= ce.quad;
  end

  // Stage U: unfold quadrant
  logic signed [31:0] sp, cp;
  sincos_t            sc_nxt;
  logic               vo_r;
  sincos_t            sc_r;

  always_comb begin
    sp = $signed({1'b0, s_r});
    cp = $signed({1'b0, c_r});
    unique case (qs_r)
      2'd0:    begin sc_nxt.s = sp;  sc_nxt.c = cp;  end
      2'd1:    begin sc_nxt.s = cp;  sc_nxt.c = -sp; end
      2'd2:    begin sc_nxt.s = -sp; sc_nxt.c = -cp; end
      default: begin sc_nxt.s = -cp; sc_nxt.c = sp;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
  end

  assign vld_o = vo_r;
  assign sc_o  = sc_r;

endmodule
`default_nettype wire
